### rtl/sst_pkg.sv
// Package for the sorted set table: operation and status codes, field widths.
// No dependencies.
package sst_pkg;
  localparam int OP_W    = 3;
  localparam int KEYF_W  = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 3;
  localparam int OCC_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0, OP_FIND = 3'd1, OP_REMOVE = 3'd2, OP_REMOVE_AT = 3'd3,
    OP_READ = 3'd4, OP_POP = 3'd5, OP_CLEAR = 3'd6, OP_BAD = 3'd7
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADIDX   = 3'd4;

  // datapath commands
  typedef enum logic [2:0] {
    DC_NONE, DC_SCAN_START, DC_SCAN_STEP, DC_INS_STEP, DC_DOWN_PRIME,
    DC_SHIFT_DOWN, DC_READ
  } dcmd_t;

  typedef struct packed {
    dcmd_t cmd;
  } sst_cmd_t;

  typedef struct packed {
    logic scan_done;  // scan stopped: idx at end or entry >= key
    logic match;      // entry at idx equals key
    logic at_count;   // idx equals the occupancy
    logic at_last;    // idx is at or past the last held position
  } sst_stat_t;
endpackage

### rtl/sst_if.sv
// Valid/ready channel interfaces for the sorted set table.
// No dependencies.
interface sst_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [31:0] key;
  logic [5:0] position;
  modport source (output valid, operation, key, position, input ready);
  modport sink (input valid, operation, key, position, output ready);
endinterface

interface sst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [5:0]  where;
  logic [31:0] value_out;
  logic [6:0]  occupancy;
  modport source (output valid, status, found, where, value_out, occupancy, input ready);
  modport sink (input valid, status, found, where, value_out, occupancy, output ready);
endinterface

### rtl/sst_datapath.sv
// Datapath: key store memory, scan/shift index, key compare and read register.
// Depends on sst_pkg.
module sst_datapath #(
  parameter int CAPACITY = 64,
  parameter int KEY_WIDTH = 32,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  sst_pkg::sst_cmd_t    cmd,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]     count,
  input  logic [IDX_W-1:0]     target,
  output sst_pkg::sst_stat_t   stat,
  output logic [CNT_W-1:0]     idx,
  output logic [KEY_WIDTH-1:0] rdata
);
  import sst_pkg::*;

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_r;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     tgt_ext;
  logic [IDX_W-1:0]     ra;
  logic                 we;
  logic [IDX_W-1:0]     wa;
  logic [KEY_WIDTH-1:0] wd;
  logic                 rd_ok_r;

  assign tgt_ext = CNT_W'(target);

  // one registered read and one write a cycle; the read returns the old entry.
  // insert ripples upward from the target: key first, then each displaced entry.
  // shift down reads one place ahead of the write after a priming read.
  always_comb begin
    idx_nxt = idx_r;
    ra = idx_r[IDX_W-1:0];
    we = 1'b0;
    wa = idx_r[IDX_W-1:0];
    wd = rd_r;
    case (cmd.cmd)
      DC_SCAN_START: begin idx_nxt = '0; ra = '0; end
      DC_SCAN_STEP: begin
        idx_nxt = idx_r + CNT_W'(1);
        ra = IDX_W'(idx_r + CNT_W'(1));
      end
      DC_INS_STEP: begin
        we = 1'b1;
        wd = (idx_r == tgt_ext) ? key : rd_r;
        idx_nxt = idx_r + CNT_W'(1);
      end
      DC_DOWN_PRIME: begin
        idx_nxt = tgt_ext;
        ra = IDX_W'(tgt_ext + CNT_W'(1));
      end
      DC_SHIFT_DOWN: begin
        we = 1'b1;
        idx_nxt = idx_r + CNT_W'(1);
        ra = IDX_W'(idx_r + CNT_W'(2));
      end
      DC_READ: ra = target;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r    <= mem[ra];
    idx_r   <= idx_nxt;
    rd_ok_r <= (cmd.cmd == DC_SCAN_START) || (cmd.cmd == DC_SCAN_STEP);
  end

  assign stat.scan_done = rd_ok_r && ((idx_r >= count) || (rd_r >= key));
  assign stat.match     = (idx_r < count) && (rd_r == key);
  assign stat.at_count  = (idx_r == count);
  assign stat.at_last   = ((idx_r + CNT_W'(1)) >= count);
  assign idx   = idx_r;
  assign rdata = rd_r;
endmodule

### rtl/sst_ctrl.sv
// Controller state machine: sequences scans and shifts, forms the result item.
// Depends on sst_pkg.
module sst_ctrl #(
  parameter int CAPACITY = 64,
  parameter int KEY_WIDTH = 32,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_op,
  input  logic [31:0]          in_key,
  input  logic [5:0]           in_pos,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic                 out_found,
  output logic [5:0]           out_where,
  output logic [31:0]          out_value,
  output logic [6:0]           out_occ,
  output sst_pkg::sst_cmd_t    cmd,
  output logic [KEY_WIDTH-1:0] key,
  output logic [CNT_W-1:0]     count,
  output logic [IDX_W-1:0]     target,
  input  sst_pkg::sst_stat_t   stat,
  input  logic [CNT_W-1:0]     idx,
  input  logic [KEY_WIDTH-1:0] rdata
);
  import sst_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UP, S_PRIME, S_DOWN, S_RD, S_OUT} state_t;

  state_t               state_r;
  op_t                  op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     tgt_r;
  logic [2:0]           st_r;
  logic                 fnd_r;
  logic [5:0]           wh_r;
  logic [31:0]          val_r;
  logic                 pos_ok;

  assign pos_ok = (32'(in_pos) < 32'(cnt_r));

  // command decode
  always_comb begin
    cmd.cmd = DC_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin
        case (op_t'(in_op))
          OP_INSERT, OP_FIND, OP_REMOVE: cmd.cmd = DC_SCAN_START;
          OP_READ, OP_POP: cmd.cmd = DC_READ;
          default:   cmd.cmd = DC_NONE;
        endcase
      end
      S_SCAN:  if (!stat.scan_done) cmd.cmd = DC_SCAN_STEP;
      S_UP:    cmd.cmd = DC_INS_STEP;
      S_PRIME: cmd.cmd = DC_DOWN_PRIME;
      S_DOWN:  if (!stat.at_last) cmd.cmd = DC_SHIFT_DOWN;
      default: cmd.cmd = DC_NONE;
    endcase
  end

  assign key    = (state_r == S_IDLE) ? KEY_WIDTH'(in_key) : key_r;
  assign count  = cnt_r;
  // pop reads the top entry, read uses the given position
  assign target = (state_r != S_IDLE) ? tgt_r :
                  (op_t'(in_op) == OP_POP) ? IDX_W'(cnt_r - CNT_W'(1)) : IDX_W'(in_pos);

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_found  = fnd_r;
  assign out_where  = wh_r;
  assign out_value  = val_r;
  assign out_occ    = OCC_W'(cnt_r);

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= op_t'(in_op); key_r <= KEY_WIDTH'(in_key); tgt_r <= IDX_W'(in_pos);
          fnd_r <= 1'b0; val_r <= '0;
          case (op_t'(in_op))
            OP_INSERT, OP_FIND, OP_REMOVE: begin
              st_r <= ST_OK; wh_r <= '0; state_r <= S_SCAN;
            end
            OP_REMOVE_AT, OP_READ: begin
              if (pos_ok) begin
                st_r <= ST_OK; wh_r <= in_pos;
                state_r <= (op_t'(in_op) == OP_READ) ? S_RD : S_PRIME;
              end else begin
                st_r <= ST_BADIDX; wh_r <= '0; state_r <= S_OUT;
              end
            end
            OP_POP: begin
              wh_r <= '0;
              if (cnt_r != '0) begin
                st_r <= ST_OK; state_r <= S_RD;
              end else begin
                st_r <= ST_BADIDX; state_r <= S_OUT;
              end
            end
            OP_CLEAR: begin
              st_r <= ST_OK; wh_r <= '0; cnt_r <= '0; state_r <= S_OUT;
            end
            default: begin
              st_r <= ST_BADIDX; wh_r <= '0; state_r <= S_OUT;
            end
          endcase
        end
        S_SCAN: if (stat.scan_done) begin
          tgt_r <= idx[IDX_W-1:0];
          if (stat.match) begin
            wh_r <= 6'(idx);
            if (op_r == OP_INSERT) begin
              st_r <= ST_DUP; state_r <= S_OUT;
            end else begin
              fnd_r <= 1'b1;
              state_r <= (op_r == OP_REMOVE) ? S_PRIME : S_OUT;
            end
          end else if (op_r == OP_INSERT) begin
            if (cnt_r >= CNT_W'(CAPACITY)) begin
              st_r <= ST_FULL; state_r <= S_OUT;
            end else begin
              wh_r <= 6'(idx); state_r <= S_UP;
            end
          end else begin
            st_r <= ST_NOTFOUND; state_r <= S_OUT;
          end
        end
        // last write lands at the old occupancy
        S_UP: if (stat.at_count) begin
          cnt_r <= cnt_r + CNT_W'(1); state_r <= S_OUT;
        end
        S_PRIME: state_r <= S_DOWN;
        S_DOWN: if (stat.at_last) begin
          cnt_r <= cnt_r - CNT_W'(1); state_r <= S_OUT;
        end
        S_RD: begin
          val_r <= 32'(rdata);
          if (op_r == OP_POP) cnt_r <= cnt_r - CNT_W'(1);
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // occupancy never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(st_r))
    else $error("result changed under stall");
  // count stays put when a result with a non-ok status is taken
  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && st_r != ST_OK |=> $stable(cnt_r))
    else $error("count moved on failed op");
endmodule

### rtl/sorted_set_table.sv
// Sorted set table top level: controller plus datapath on valid/ready channels.
// Depends on sst_pkg, sst_if, sst_ctrl, sst_datapath.
//
// Usage: one input item (operation, key, position) gives one result item
// (status, found, where, value_out, occupancy). Input is taken only while the
// block is idle; the result is held in registers until out.ready is high.
// Find, insert and remove scan the ordered memory from position 0, one entry
// a cycle, up to p, the lower-bound position. An insert then writes the new
// key at p and moves later keys up one place, up to the occupancy n; a
// removal primes one read and moves later keys down one place. Read and pop
// read one entry, remove-at shifts down from the given position, and clear
// and errors go straight to the result. All of these steps share the single
// registered read port of the key memory.
// Reset empties the set at once (occupancy only; stored keys are not
// cleared). A stalled receiver holds the result and no new item is taken.
module sorted_set_table #(
  parameter int CAPACITY = 64,
  parameter int KEY_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch
);
  import sst_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  sst_cmd_t             cmd;
  sst_stat_t            stat;
  logic [KEY_WIDTH-1:0] key;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [IDX_W-1:0]     target;
  logic [KEY_WIDTH-1:0] rdata;

  sst_ctrl #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.operation),
    .in_key(in_ch.key), .in_pos(in_ch.position),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
    .out_found(out_ch.found), .out_where(out_ch.where), .out_value(out_ch.value_out),
    .out_occ(out_ch.occupancy),
    .cmd, .key, .count, .target, .stat, .idx, .rdata
  );

  sst_datapath #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .IDX_W(IDX_W), .CNT_W(CNT_W))
    u_dp (.clk, .cmd, .key, .count, .target, .stat, .idx, .rdata);
endmodule
